// ----- rtl/core/xypr_pkg.sv -----
// xypr_pkg: shared types, codes and constants of the xy path recorder/player
// no dependencies; used by the interfaces, xypr_front, xypr_back and the top level
`timescale 1ns / 1ps

package xypr_pkg;

	// default sizes handed to the top level parameters
	localparam int PATH_DEPTH_DEF  = 1024;
	localparam int COORD_BITS_DEF  = 12;

	// fixed field widths
	localparam int REQ_W        = 2;
	localparam int POS_W        = 12;
	localparam int MV_W         = 14;
	localparam int PLAY_POS_W   = 10;
	localparam int GAIN_W       = 13;
	localparam int STEP_W       = 25;
	localparam int PHASE_W      = 24;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 25;

	// arithmetic constants
	localparam logic [GAIN_W-1:0] GAIN_UNITY    = 13'd4096;
	localparam logic [STEP_W-1:0] PHASE_ONE     = 25'd16777216;
	localparam int                FULL_SCALE_MV = 5000;

	// front-to-back queue depth
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_POINT = 2'd2,
		REQ_END   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_FORWARD  = 2'd0,
		MODE_PINGPONG = 2'd1,
		MODE_REVERSE  = 2'd2
	} play_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PLAY_MODE  = 3'd0,
		REG_X_BIPOLAR  = 3'd1,
		REG_Y_BIPOLAR  = 3'd2,
		REG_X_GAIN     = 3'd3,
		REG_Y_GAIN     = 3'd4,
		REG_PHASE_STEP = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        play_mode;
		logic              x_bipolar;
		logic              y_bipolar;
		logic [GAIN_W-1:0] x_gain;
		logic [GAIN_W-1:0] y_gain;
		logic [STEP_W-1:0] phase_step;
	} cfg_t;

	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 25'd20972;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL1 = 2'd1,
		ST_MUL2 = 2'd2,
		ST_DONE = 2'd3
	} back_state_t;

endpackage

// ----- rtl/core/xypr_if.sv -----
// xypr_item_if / xypr_result_if: valid/ready channels of the recorder/player
// depends on xypr_pkg for field widths
`timescale 1ns / 1ps

interface xypr_item_if;
	logic                          valid;
	logic                          ready;
	logic [xypr_pkg::REQ_W-1:0]    req_type;
	logic [xypr_pkg::POS_W-1:0]    pos_x;
	logic [xypr_pkg::POS_W-1:0]    pos_y;

	modport source (output valid, output req_type, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input req_type, input pos_x, input pos_y, output ready);
endinterface

interface xypr_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [xypr_pkg::MV_W-1:0]   x_mv;
	logic signed [xypr_pkg::MV_W-1:0]   y_mv;
	logic [xypr_pkg::PLAY_POS_W-1:0]    play_position;
	logic                               is_recording;

	modport source (output valid, output x_mv, output y_mv, output play_position,
		output is_recording, input ready);
	modport sink   (input valid, input x_mv, input y_mv, input play_position,
		input is_recording, output ready);
endinterface

// ----- rtl/core/xypr_ram.sv -----
// xypr_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module xypr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/xypr_front.sv -----
// xypr_front: accepts items, converts coordinates and queues them for the back end
// depends on xypr_pkg and xypr_item_if
`timescale 1ns / 1ps

module xypr_front #(
	parameter int COORD_BITS = xypr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	xypr_item_if.sink             item,
	output logic                  q_valid,
	output xypr_pkg::req_t        q_req,
	output logic [COORD_BITS-1:0] q_x,
	output logic [COORD_BITS-1:0] q_y,
	input  logic                  q_pop
);

	localparam int QD    = xypr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(QD);
	localparam int CNT_W = $clog2(QD + 1);
	localparam int SH_W  = xypr_pkg::POS_W + COORD_BITS;

	xypr_pkg::req_t        req_mem_q [QD];
	logic [COORD_BITS-1:0] x_mem_q   [QD];
	logic [COORD_BITS-1:0] y_mem_q   [QD];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  push, pop;
	logic [SH_W-1:0]       x_sh, y_sh;

	// q12 to coordinate scale: times 2^COORD_BITS, over 4096
	assign x_sh = {item.pos_x, {COORD_BITS{1'b0}}};
	assign y_sh = {item.pos_y, {COORD_BITS{1'b0}}};

	assign item.ready = (count_q != CNT_W'(QD));
	assign push       = item.valid && item.ready;
	assign pop        = q_pop && q_valid;

	assign q_valid = (count_q != '0);
	assign q_req   = req_mem_q[rd_ptr_q];
	assign q_x     = x_mem_q[rd_ptr_q];
	assign q_y     = y_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			req_mem_q[wr_ptr_q] <= xypr_pkg::req_t'(item.req_type);
			x_mem_q[wr_ptr_q]   <= x_sh[SH_W-1:xypr_pkg::POS_W];
			y_mem_q[wr_ptr_q]   <= y_sh[SH_W-1:xypr_pkg::POS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/xypr_back.sv -----
// xypr_back: executes queued items, keeps path state, scales outputs to millivolts
// depends on xypr_pkg, xypr_result_if and xypr_ram
`timescale 1ns / 1ps

module xypr_back #(
	parameter int PATH_DEPTH = xypr_pkg::PATH_DEPTH_DEF,
	parameter int COORD_BITS = xypr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xypr_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	input  xypr_pkg::req_t        q_req,
	input  logic [COORD_BITS-1:0] q_x,
	input  logic [COORD_BITS-1:0] q_y,
	output logic                  q_pop,
	xypr_result_if.source         result
);

	localparam int CB    = COORD_BITS;
	localparam int IDX_W = $clog2(PATH_DEPTH);
	localparam int LEN_W = $clog2(PATH_DEPTH + 1);
	localparam int PT_W  = 2 * CB;
	localparam int MAG_W = CB + 1;
	localparam int P1_W  = MAG_W + xypr_pkg::GAIN_W;
	localparam int P2_W  = P1_W + 13;
	localparam int PW    = xypr_pkg::PHASE_W;
	localparam int SW    = xypr_pkg::STEP_W;
	localparam int MW    = xypr_pkg::MV_W;

	xypr_pkg::back_state_t state_q, state_d;

	// architectural state
	logic [LEN_W-1:0]    len_q, len_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                fwd_q, fwd_d;
	logic [PW-1:0]       acc_q, acc_d;
	logic                rec_q, rec_d;
	logic [CB-1:0]       live_x_q, live_y_q;
	logic signed [MW-1:0] held_q [2];
	logic                out_valid_q;
	logic                load_q, src_ram_q;

	// control
	logic go, wr_en, rd_en, ld, src_ram;

	// execute-stage datapath
	logic [SW-1:0]    step_sat, phase_sum;
	logic [LEN_W-1:0] last, ic_ext, inc;
	logic [IDX_W-1:0] ic, adv_idx;
	logic             at_end, adv_fwd, room;

	// scaling datapath
	logic [PT_W-1:0]          rd_data;
	logic [CB-1:0]            crd   [2];
	logic                     bip   [2];
	logic [xypr_pkg::GAIN_W-1:0] gain_raw [2];
	logic [xypr_pkg::GAIN_W-1:0] gain_sat [2];
	logic [MAG_W-1:0]         twice [2];
	logic [MAG_W-1:0]         mag   [2];
	logic                     neg   [2];
	logic [P1_W-1:0]          prod1_s1 [2];
	logic                     neg_s1   [2];
	logic [P2_W-1:0]          prod2_s2 [2];
	logic                     neg_s2   [2];
	logic [P2_W-1:0]          rnd   [2];
	logic [MW-1:0]            mag_mv [2];
	logic [MW-1:0]            held_d [2];
	logic [IDX_W+xypr_pkg::PLAY_POS_W-1:0] pos_wide;

	// ---------------- fsm: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			xypr_pkg::ST_IDLE: begin
				if (go) begin
					state_d = ld ? xypr_pkg::ST_MUL1 : xypr_pkg::ST_DONE;
				end
			end
			xypr_pkg::ST_MUL1: state_d = xypr_pkg::ST_MUL2;
			xypr_pkg::ST_MUL2: state_d = xypr_pkg::ST_DONE;
			xypr_pkg::ST_DONE: state_d = xypr_pkg::ST_IDLE;
			default:           state_d = xypr_pkg::ST_IDLE;
		endcase
	end

	// ---------------- fsm: outputs ----------------
	always_comb begin
		go    = (state_q == xypr_pkg::ST_IDLE) && q_valid && (!out_valid_q || result.ready);
		q_pop = go;
		wr_en = go && (q_req == xypr_pkg::REQ_POINT) && rec_q && room;
		rd_en = go && ld && src_ram;
	end

	// ---------------- execute: classify and update path state ----------------
	always_comb begin
		step_sat  = (cfg.phase_step > xypr_pkg::PHASE_ONE) ? xypr_pkg::PHASE_ONE : cfg.phase_step;
		phase_sum = {1'b0, acc_q} + step_sat;
		room      = (len_q < LEN_W'(PATH_DEPTH));

		// stale index is clamped into the recorded range first
		last   = len_q - 1'b1;
		ic     = ({{(LEN_W - IDX_W){1'b0}}, idx_q} >= len_q) ? last[IDX_W-1:0] : idx_q;
		ic_ext = {{(LEN_W - IDX_W){1'b0}}, ic};
		inc    = ic_ext + 1'b1;
		at_end = (inc >= len_q);

		adv_fwd = fwd_q;
		adv_idx = ic;
		case (cfg.play_mode)
			xypr_pkg::MODE_FORWARD: begin
				adv_fwd = 1'b1;
				adv_idx = at_end ? '0 : inc[IDX_W-1:0];
			end
			xypr_pkg::MODE_PINGPONG: begin
				if (ic == '0) begin
					adv_fwd = 1'b1;
				end else if (ic_ext == last) begin
					adv_fwd = 1'b0;
				end
				if (adv_fwd) begin
					adv_idx = at_end ? last[IDX_W-1:0] : inc[IDX_W-1:0];
				end else begin
					adv_idx = ic - 1'b1;
				end
			end
			xypr_pkg::MODE_REVERSE: begin
				adv_fwd = 1'b0;
				adv_idx = (ic == '0) ? last[IDX_W-1:0] : ic - 1'b1;
			end
			default: begin
				// unused mode code: index holds at its clamped place
				adv_idx = ic;
			end
		endcase

		len_d   = len_q;
		idx_d   = idx_q;
		fwd_d   = fwd_q;
		acc_d   = acc_q;
		rec_d   = rec_q;
		ld      = 1'b0;
		src_ram = 1'b0;
		case (q_req)
			xypr_pkg::REQ_TICK: begin
				if (rec_q || (len_q == '0)) begin
					ld = 1'b1;
				end else begin
					acc_d = phase_sum[PW-1:0];
					if (phase_sum[PW]) begin
						idx_d   = adv_idx;
						fwd_d   = adv_fwd;
						ld      = 1'b1;
						src_ram = 1'b1;
					end
				end
			end
			xypr_pkg::REQ_START: begin
				len_d = '0;
				rec_d = 1'b1;
			end
			xypr_pkg::REQ_POINT: begin
				if (rec_q && room) begin
					len_d = len_q + 1'b1;
				end
			end
			xypr_pkg::REQ_END: begin
				rec_d = 1'b0;
			end
			default: begin
				rec_d = rec_q;
			end
		endcase
	end

	xypr_ram #(
		.WIDTH (PT_W),
		.DEPTH (PATH_DEPTH)
	) u_path_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[IDX_W-1:0]),
		.wr_data ({q_x, q_y}),
		.rd_en   (rd_en),
		.rd_addr (adv_idx),
		.rd_data (rd_data)
	);

	// ---------------- scaling: bipolar map, gain, millivolts ----------------
	always_comb begin
		crd[0]      = src_ram_q ? rd_data[PT_W-1:CB] : live_x_q;
		crd[1]      = src_ram_q ? rd_data[CB-1:0] : live_y_q;
		bip[0]      = cfg.x_bipolar;
		bip[1]      = cfg.y_bipolar;
		gain_raw[0] = cfg.x_gain;
		gain_raw[1] = cfg.y_gain;
		for (int a = 0; a < 2; a++) begin
			gain_sat[a] = (gain_raw[a] > xypr_pkg::GAIN_UNITY) ? xypr_pkg::GAIN_UNITY
				: gain_raw[a];
			twice[a] = {crd[a], 1'b0};
			neg[a]   = 1'b0;
			if (!bip[a]) begin
				mag[a] = {1'b0, crd[a]};
			end else if (twice[a] >= {1'b1, {CB{1'b0}}}) begin
				mag[a] = twice[a] - {1'b1, {CB{1'b0}}};
			end else begin
				mag[a] = {1'b1, {CB{1'b0}}} - twice[a];
				neg[a] = 1'b1;
			end
			// round half away from zero on the magnitude
			rnd[a]    = prod2_s2[a] + (P2_W'(1) << (CB + 11));
			mag_mv[a] = {1'b0, rnd[a][CB+24:CB+12]};
			held_d[a] = neg_s2[a] ? (~mag_mv[a] + 1'b1) : mag_mv[a];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			prod1_s1[a] <= P1_W'(mag[a]) * P1_W'(gain_sat[a]);
			neg_s1[a]   <= neg[a];
			prod2_s2[a] <= P2_W'(prod1_s1[a]) * P2_W'(xypr_pkg::FULL_SCALE_MV);
			neg_s2[a]   <= neg_s1[a];
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xypr_pkg::ST_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			fwd_q       <= 1'b1;
			acc_q       <= '0;
			rec_q       <= 1'b0;
			live_x_q    <= '0;
			live_y_q    <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
			out_valid_q <= 1'b0;
			load_q      <= 1'b0;
			src_ram_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go) begin
				len_q     <= len_d;
				idx_q     <= idx_d;
				fwd_q     <= fwd_d;
				acc_q     <= acc_d;
				rec_q     <= rec_d;
				load_q    <= ld;
				src_ram_q <= src_ram;
				if (q_req == xypr_pkg::REQ_POINT) begin
					live_x_q <= q_x;
					live_y_q <= q_y;
				end
			end
			if (state_q == xypr_pkg::ST_DONE) begin
				out_valid_q <= 1'b1;
				if (load_q) begin
					held_q[0] <= held_d[0];
					held_q[1] <= held_d[1];
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result fields come straight from state, which holds until the item is taken
	assign pos_wide             = {{xypr_pkg::PLAY_POS_W{1'b0}}, idx_q};
	assign result.valid         = out_valid_q;
	assign result.x_mv          = held_q[0];
	assign result.y_mv          = held_q[1];
	assign result.play_position = pos_wide[xypr_pkg::PLAY_POS_W-1:0];
	assign result.is_recording  = rec_q;

endmodule

// ----- rtl/core/xy_path_recorder_player.sv -----
// xy_path_recorder_player: records an x/y path and plays it back in millivolts
// path: a tick that loads a point passes the input queue, the path ram read when playing
// back and the two multiplier stages; other items pass the queue and the execute step
// sequencing: the back-end sequencer takes no new item until the last has passed its done
// state, and holds while a result waits to be taken
// reset: arst_n clears control, config to defaults, outputs to zero; path ram not cleared
`timescale 1ns / 1ps

module xy_path_recorder_player #(
	parameter int PATH_DEPTH = xypr_pkg::PATH_DEPTH_DEF,
	parameter int COORD_BITS = xypr_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [xypr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [xypr_pkg::CFG_DATA_W-1:0]   cfg_data,
	xypr_item_if.sink                         item,
	xypr_result_if.source                     result
);

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	xypr_pkg::cfg_t cfg_q;

	// queue between front (accept, coordinate scaling) and back (execution)
	logic                  q_valid;
	xypr_pkg::req_t        q_req;
	logic [COORD_BITS-1:0] q_x;
	logic [COORD_BITS-1:0] q_y;
	logic                  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.play_mode  <= xypr_pkg::MODE_FORWARD;
			cfg_q.x_bipolar  <= 1'b0;
			cfg_q.y_bipolar  <= 1'b0;
			cfg_q.x_gain     <= xypr_pkg::GAIN_UNITY;
			cfg_q.y_gain     <= xypr_pkg::GAIN_UNITY;
			cfg_q.phase_step <= xypr_pkg::PHASE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				xypr_pkg::REG_PLAY_MODE:  cfg_q.play_mode  <= cfg_data[1:0];
				xypr_pkg::REG_X_BIPOLAR:  cfg_q.x_bipolar  <= cfg_data[0];
				xypr_pkg::REG_Y_BIPOLAR:  cfg_q.y_bipolar  <= cfg_data[0];
				xypr_pkg::REG_X_GAIN:     cfg_q.x_gain     <= cfg_data[xypr_pkg::GAIN_W-1:0];
				xypr_pkg::REG_Y_GAIN:     cfg_q.y_gain     <= cfg_data[xypr_pkg::GAIN_W-1:0];
				xypr_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[xypr_pkg::STEP_W-1:0];
				default: begin
					// writes beyond the register list are ignored
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: takes items while its queue has room, converts q12 positions to the coordinate width
	xypr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_valid (q_valid),
		.q_req   (q_req),
		.q_x     (q_x),
		.q_y     (q_y),
		.q_pop   (q_pop)
	);

	// back: path store, play index stepping, bipolar map and gain to millivolts
	xypr_back #(
		.PATH_DEPTH (PATH_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_req   (q_req),
		.q_x     (q_x),
		.q_y     (q_y),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
